// ----- rtl/dbbt_pkg.sv -----
// Shared types and constants for the download byte budget throttle.
// No dependencies; used by dbbt_cfg, dbbt_div and the top level.
package dbbt_pkg;

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    KIND_SETUP  = 2'd0,
    KIND_SLICE  = 2'd1,
    KIND_RETURN = 2'd2
  } kind_e;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_THROTTLE_ON = 2'd0,
    REG_LIMIT_KIB   = 2'd1,
    REG_SOCK_BUF    = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_CMP,
    ST_DIV_GO,
    ST_DIV,
    ST_SLICE,
    ST_GRANT,
    ST_RETURN,
    ST_EMIT
  } state_e;

  localparam int unsigned DivW     = 34;  // dividend / quotient width
  localparam int unsigned DivisorW = 30;

  localparam logic [15:0]         MaxTransfers  = 16'd255;
  localparam logic [6:0]          CycleFullMs   = 7'd100;
  localparam logic [DivW-1:0]     MsPerSec      = 34'd1000;
  localparam logic [23:0]         SockBufReset  = 24'd65536;

  typedef struct packed {
    logic        throttle_on;
    logic [19:0] limit_kib;
    logic [23:0] sock_buf;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/dbbt_cfg.sv -----
// APB-style configuration registers of the download byte budget throttle.
// Depends on dbbt_pkg (cfg_t, reg_idx_e, SockBufReset).
module dbbt_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output dbbt_pkg::cfg_t    cfg_o
);

  dbbt_pkg::cfg_t   cfg_q, cfg_d;
  dbbt_pkg::reg_idx_e idx;

  assign idx    = dbbt_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite && pready) begin
      case (idx)
        dbbt_pkg::REG_THROTTLE_ON: cfg_d.throttle_on = pwdata[0];
        dbbt_pkg::REG_LIMIT_KIB:   cfg_d.limit_kib   = pwdata[19:0];
        dbbt_pkg::REG_SOCK_BUF:    cfg_d.sock_buf    = pwdata[23:0];
        default:                   cfg_d             = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dbbt_pkg::REG_THROTTLE_ON: prdata = {31'd0, cfg_q.throttle_on};
      dbbt_pkg::REG_LIMIT_KIB:   prdata = {12'd0, cfg_q.limit_kib};
      dbbt_pkg::REG_SOCK_BUF:    prdata = {8'd0, cfg_q.sock_buf};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.throttle_on <= 1'b0;
      cfg_q.limit_kib   <= 20'd0;
      cfg_q.sock_buf    <= dbbt_pkg::SockBufReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- rtl/dbbt_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
// Depends on dbbt_pkg (DivW, DivisorW, div_stat_t). Divisor must be nonzero.
module dbbt_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [dbbt_pkg::DivW-1:0]         dividend_i,
  input  logic [dbbt_pkg::DivisorW-1:0]     divisor_i,
  output logic [dbbt_pkg::DivW-1:0]         quotient_o,
  output dbbt_pkg::div_stat_t               stat_o
);

  localparam int unsigned CntW = $clog2(dbbt_pkg::DivW + 1);

  logic [dbbt_pkg::DivW-1:0]     quo_q;
  logic [dbbt_pkg::DivisorW-1:0] rem_q, dvs_q;
  logic [CntW-1:0]               cnt_q;
  logic                          busy_q, done_q;
  logic [dbbt_pkg::DivisorW:0]   shifted;
  logic                          fits;

  // partial remainder with the next dividend bit shifted in
  assign shifted = {rem_q, quo_q[dbbt_pkg::DivW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(dbbt_pkg::DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[dbbt_pkg::DivW-2:0], fits};
      rem_q <= fits ? dbbt_pkg::DivisorW'(shifted - {1'b0, dvs_q})
                    : shifted[dbbt_pkg::DivisorW-1:0];
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- rtl/download_byte_budget_throttle.sv -----
// Top level of the download byte budget throttle: sequencer, budget state and
// output register. Depends on dbbt_pkg, dbbt_cfg and dbbt_div.
//  - Requests arrive on s_axis (tuser = kind, tdata = transfers and returned
//    bytes). A setup request once a second loads the byte budget from the
//    limit register, decides whether throttling is on and derives the slice
//    size and read cycle time; slice requests draw from the budget and return
//    requests hand unused bytes back.
//  - Every request yields exactly one result on m_axis: granted bytes, the
//    unlimited flag, the current throttling state and the cycle time.
//  - One request at a time: s_axis_tready is high only while idle. Setup with
//    throttling on passes the setup, multiply and compare states and then
//    the serial divider, shared by both divisions. Other setups, returns and
//    slices while off go straight to the result, slices while on via a grant
//    state, unused kinds at once; the next request can follow in the cycle after the result is stored.
//  - The result sits in an output register; the next request is accepted
//    while it waits. If the receiver stalls, a finished result waits in the
//    sequencer until the output register frees up.
//  - Reset clears all budget state and the result valid flag; the socket
//    buffer register resets to 64 KiB. The user must write registers over APB
//    only while no request is in flight; the block itself does not enforce it.
module download_byte_budget_throttle (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] active_transfers, [32:8] returned_bytes
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [29:0] slice_bytes, [36:30] cycle_time_ms
  output logic [1:0]  m_axis_tuser,   // [0] unlimited, [1] throttling
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dbbt_pkg::cfg_t      cfg;
  dbbt_pkg::div_stat_t div_stat;
  dbbt_pkg::state_e    state_q, state_d;

  // latched request
  logic [7:0]      xfers_q;
  logic [24:0]     ret_q;

  // budget state
  logic [29:0] budget_q, granted_q;
  logic [23:0] slice_q;
  logic        enabled_q;
  logic [6:0]  cycle_q;

  // setup datapath
  logic [11:0] ten_n_q;
  logic [10:0] seven_n_q;
  logic [35:0] prod_q;
  logic        full_q;       // budget above ten buffers per transfer
  logic [30:0] left_q;       // signed remainder of the budget

  // per-request result
  logic [29:0] grant_q;
  logic        unl_q;

  // output register
  logic        out_vld_q;
  logic [29:0] out_slice_q;
  logic [6:0]  out_cycle_q;
  logic        out_unl_q, out_thr_q;

  // control
  logic        accept, load_out, div_start;
  logic [dbbt_pkg::DivW-1:0]     div_dividend, div_quo;
  logic [dbbt_pkg::DivisorW-1:0] div_divisor;

  // setup combinational helpers
  logic [7:0]  n_clamped;
  logic [29:0] budget_new;
  logic        enable_new;
  logic [30:0] twice_slice;

  dbbt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dbbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  // transfer count clamped to the supported maximum
  assign n_clamped  = ({8'd0, xfers_q} > dbbt_pkg::MaxTransfers) ?
                      dbbt_pkg::MaxTransfers[7:0] : xfers_q;
  assign budget_new = {cfg.limit_kib, 10'd0};
  assign enable_new = cfg.throttle_on && (budget_new != 30'd0) && (n_clamped != 8'd0);
  assign twice_slice = {6'd0, slice_q, 1'b0};

  // slice-size division, or cycle-time division when the budget is large
  assign div_dividend = full_q ? prod_q[dbbt_pkg::DivW-1:0] : {4'd0, budget_q};
  assign div_divisor  = full_q ? budget_q : {19'd0, seven_n_q};

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      dbbt_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (dbbt_pkg::kind_e'(s_axis_tuser))
            dbbt_pkg::KIND_SETUP:  state_d = dbbt_pkg::ST_SETUP;
            dbbt_pkg::KIND_SLICE:  state_d = dbbt_pkg::ST_SLICE;
            dbbt_pkg::KIND_RETURN: state_d = dbbt_pkg::ST_RETURN;
            default:               state_d = dbbt_pkg::ST_EMIT;
          endcase
        end
      end
      dbbt_pkg::ST_SETUP:  state_d = enable_new ? dbbt_pkg::ST_MUL : dbbt_pkg::ST_EMIT;
      dbbt_pkg::ST_MUL:    state_d = dbbt_pkg::ST_CMP;
      dbbt_pkg::ST_CMP:    state_d = dbbt_pkg::ST_DIV_GO;
      dbbt_pkg::ST_DIV_GO: state_d = dbbt_pkg::ST_DIV;
      dbbt_pkg::ST_DIV:    if (div_stat.done) state_d = dbbt_pkg::ST_EMIT;
      dbbt_pkg::ST_SLICE:  state_d = enabled_q ? dbbt_pkg::ST_GRANT : dbbt_pkg::ST_EMIT;
      dbbt_pkg::ST_GRANT:  state_d = dbbt_pkg::ST_EMIT;
      dbbt_pkg::ST_RETURN: state_d = dbbt_pkg::ST_EMIT;
      dbbt_pkg::ST_EMIT:   if (!out_vld_q || m_axis_tready) state_d = dbbt_pkg::ST_IDLE;
      default:             state_d = dbbt_pkg::ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    div_start     = 1'b0;
    case (state_q)
      dbbt_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      dbbt_pkg::ST_DIV_GO: div_start     = 1'b1;
      dbbt_pkg::ST_EMIT:   load_out      = !out_vld_q || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dbbt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- budget state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q  <= 30'd0;
      granted_q <= 30'd0;
      slice_q   <= 24'd0;
      enabled_q <= 1'b0;
      cycle_q   <= 7'd0;
    end else begin
      case (state_q)
        dbbt_pkg::ST_SETUP: begin
          budget_q  <= budget_new;
          enabled_q <= enable_new;
          granted_q <= 30'd0;
        end
        dbbt_pkg::ST_DIV: begin
          if (div_stat.done) begin
            if (full_q) begin
              slice_q <= cfg.sock_buf;
              cycle_q <= div_quo[6:0];
            end else begin
              // slice capped at the socket buffer
              slice_q <= (div_quo > {10'd0, cfg.sock_buf}) ? cfg.sock_buf : div_quo[23:0];
              cycle_q <= dbbt_pkg::CycleFullMs;
            end
          end
        end
        dbbt_pkg::ST_GRANT: begin
          if (!left_q[30] && left_q != 31'd0) begin
            if (left_q > twice_slice) begin
              granted_q <= granted_q + {6'd0, slice_q};
            end else begin
              granted_q <= granted_q + left_q[29:0];
            end
          end
        end
        dbbt_pkg::ST_RETURN: begin
          // small returns only, floored at zero
          if (ret_q != 25'd0 && ret_q < {slice_q, 1'b0}) begin
            granted_q <= (granted_q >= {5'd0, ret_q}) ? granted_q - {5'd0, ret_q} : 30'd0;
          end
        end
        default: begin
          granted_q <= granted_q;
        end
      endcase
    end
  end

  // ---------------- request and arithmetic registers ----------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      xfers_q <= s_axis_tdata[7:0];
      ret_q   <= s_axis_tdata[32:8];
      grant_q <= 30'd0;
      unl_q   <= 1'b0;
    end
    case (state_q)
      dbbt_pkg::ST_SETUP: begin
        ten_n_q   <= ({4'd0, n_clamped} << 3) + ({4'd0, n_clamped} << 1);
        seven_n_q <= ({3'd0, n_clamped} << 3) - {3'd0, n_clamped};
      end
      dbbt_pkg::ST_MUL: begin
        prod_q <= {12'd0, cfg.sock_buf} * {24'd0, ten_n_q};
      end
      dbbt_pkg::ST_CMP: begin
        full_q <= {6'd0, budget_q} > prod_q;
        prod_q <= {2'd0, dbbt_pkg::DivW'(cfg.sock_buf) * dbbt_pkg::MsPerSec};
      end
      dbbt_pkg::ST_SLICE: begin
        left_q <= {1'b0, budget_q} - {1'b0, granted_q};
        unl_q  <= !enabled_q;
      end
      dbbt_pkg::ST_GRANT: begin
        if (!left_q[30] && left_q != 31'd0) begin
          grant_q <= (left_q > twice_slice) ? {6'd0, slice_q} : left_q[29:0];
        end
      end
      default: begin
        full_q <= full_q;
      end
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_slice_q <= grant_q;
      out_unl_q   <= unl_q;
      out_thr_q   <= enabled_q;
      out_cycle_q <= cycle_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'd0, out_cycle_q, out_slice_q};
  assign m_axis_tuser  = {out_thr_q, out_unl_q};

`ifndef SYNTHESIS
  // throttling is only on with a nonzero budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    enabled_q |-> (budget_q != 30'd0))
    else $error("throttling enabled with empty budget");

  // grants never exceed the budget
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    granted_q <= budget_q)
    else $error("granted bytes above budget");

  // the divider only runs while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_stat.busy || div_stat.done) |-> (state_q == dbbt_pkg::ST_DIV))
    else $error("divider active outside division state");

  // an unlimited answer grants no bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[29:0] == 30'd0))
    else $error("unlimited result with nonzero grant");

  // a result is loaded only after a request was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> !s_axis_tready)
    else $error("result loaded while idle");
`endif

endmodule
